// ===== sv/brne_pkg.sv =====
package brne_pkg;

  localparam int VALUE_W      = 14;
  localparam int SYMBOL_W     = 8;
  localparam int DIGITS       = 4;
  localparam int BCD_W        = 4 * DIGITS;
  localparam int SPLIT_CYCLES = VALUE_W;
  localparam int CNT_W        = $clog2(SPLIT_CYCLES);

  localparam logic [VALUE_W-1:0] MAX_ROMAN = VALUE_W'(3999);

  localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;
  localparam logic [SYMBOL_W-1:0] CH_I    = 8'h49;
  localparam logic [SYMBOL_W-1:0] CH_V    = 8'h56;
  localparam logic [SYMBOL_W-1:0] CH_X    = 8'h58;
  localparam logic [SYMBOL_W-1:0] CH_L    = 8'h4c;
  localparam logic [SYMBOL_W-1:0] CH_C    = 8'h43;
  localparam logic [SYMBOL_W-1:0] CH_D    = 8'h44;
  localparam logic [SYMBOL_W-1:0] CH_M    = 8'h4d;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_kind_t;

  // number of characters a decimal digit turns into
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] len;
    len = 3'd0;
    case (d) inside
      4'd1, 4'd2, 4'd3:         len = 3'(d);
      4'd4:                     len = 3'd2;
      4'd5:                     len = 3'd1;
      4'd6, 4'd7, 4'd8:         len = 3'(d - 4'd4);
      4'd9:                     len = 3'd2;
      default:                  len = 3'd0;
    endcase
    return len;
  endfunction

  // which of the one/five/ten letters stands at position k of a digit
  function automatic sym_kind_t digit_kind(input logic [3:0] d, input logic [1:0] k);
    sym_kind_t kind;
    kind = SYM_ONE;
    case (d) inside
      4'd4:                     kind = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd9:                     kind = (k == 2'd0) ? SYM_ONE : SYM_TEN;
      4'd5, 4'd6, 4'd7, 4'd8:   kind = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
      default:                  kind = SYM_ONE;
    endcase
    return kind;
  endfunction

  // place 0 is thousands, 3 is units
  function automatic logic [SYMBOL_W-1:0] roman_char(input logic [1:0] place,
                                                     input sym_kind_t kind);
    logic [SYMBOL_W-1:0] ch;
    ch = CH_NONE;
    unique case (place)
      2'd0: ch = (kind == SYM_ONE) ? CH_M : CH_NONE;
      2'd1: begin
        unique case (kind)
          SYM_ONE:  ch = CH_C;
          SYM_FIVE: ch = CH_D;
          SYM_TEN:  ch = CH_M;
          default:  ch = CH_NONE;
        endcase
      end
      2'd2: begin
        unique case (kind)
          SYM_ONE:  ch = CH_X;
          SYM_FIVE: ch = CH_L;
          SYM_TEN:  ch = CH_C;
          default:  ch = CH_NONE;
        endcase
      end
      default: begin
        unique case (kind)
          SYM_ONE:  ch = CH_I;
          SYM_FIVE: ch = CH_V;
          SYM_TEN:  ch = CH_X;
          default:  ch = CH_NONE;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/binary_to_roman_numeral_encoder_core.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------
// input    | in_valid / in_stall   | value[13:0]
// output   | out_valid / out_stall | symbol[7:0], last, empty_res, out_of_range
//
// one word in, then a shift-add-3 digit split over the 14 value bits (one bit
// per cycle), then one character per cycle while the output is not stalled; a zero
// digit ahead of the last nonzero one takes a state step of its own with no character.
// zero and out-of-range values skip the split and give a single flag word.
// rst is synchronous and clears the control state and out_valid.
// in_stall is high until the last word is loaded; a stalled word holds back the next word, not the split.
module binary_to_roman_numeral_encoder_core
  import brne_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [VALUE_W-1:0]  value,
  input  logic                in_valid,
  output logic                in_stall,
  output logic [SYMBOL_W-1:0] symbol,
  output logic                last,
  output logic                empty_res,
  output logic                out_of_range,
  output logic                out_valid,
  input  logic                out_stall
);

  state_t               state, state_next;
  logic [VALUE_W-1:0]   sh, sh_next;
  logic [BCD_W-1:0]     bcd, bcd_next, adj;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [1:0]           p, p_next;
  logic [1:0]           k, k_next;
  logic                 flag_empty, flag_empty_next;
  logic                 flag_oor, flag_oor_next;
  logic                 out_valid_next;
  logic                 out_free, load;
  logic [SYMBOL_W-1:0]  sym_d;
  logic                 last_d;
  logic [3:0]           cur_d;
  logic [2:0]           cur_len;
  logic                 rest_zero;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // add 3 to every bcd digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // current digit and whether all lower places are zero
  always_comb begin
    unique case (p)
      2'd0: begin
        cur_d     = bcd[15:12];
        rest_zero = (bcd[11:0] == 12'd0);
      end
      2'd1: begin
        cur_d     = bcd[11:8];
        rest_zero = (bcd[7:0] == 8'd0);
      end
      2'd2: begin
        cur_d     = bcd[7:4];
        rest_zero = (bcd[3:0] == 4'd0);
      end
      default: begin
        cur_d     = bcd[3:0];
        rest_zero = 1'b1;
      end
    endcase
  end

  assign cur_len = digit_len(cur_d);

  always_comb begin
    state_next      = state;
    sh_next         = sh;
    bcd_next        = bcd;
    cnt_next        = cnt;
    p_next          = p;
    k_next          = k;
    flag_empty_next = flag_empty;
    flag_oor_next   = flag_oor;
    load            = 1'b0;
    sym_d           = CH_NONE;
    last_d          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          flag_empty_next = (value == '0);
          flag_oor_next   = (value > MAX_ROMAN);
          sh_next         = value;
          bcd_next        = '0;
          cnt_next        = '0;
          p_next          = 2'd0;
          k_next          = 2'd0;
          state_next      = ((value == '0) || (value > MAX_ROMAN)) ? ST_EMIT : ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        bcd_next = {adj[BCD_W-2:0], sh[VALUE_W-1]};
        sh_next  = {sh[VALUE_W-2:0], 1'b0};
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(SPLIT_CYCLES - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (flag_empty || flag_oor) begin
          if (out_free) begin
            load       = 1'b1;
            last_d     = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (cur_len == 3'd0) begin
          p_next = p + 2'd1;
        end else if (out_free) begin
          load   = 1'b1;
          sym_d  = roman_char(p, digit_kind(cur_d, k));
          last_d = ({1'b0, k} == cur_len - 3'd1) && rest_zero;
          if ({1'b0, k} == cur_len - 3'd1) begin
            k_next = 2'd0;
            p_next = p + 2'd1;
            if (rest_zero) begin
              state_next = ST_IDLE;
            end
          end else begin
            k_next = k + 2'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      p         <= 2'd0;
      k         <= 2'd0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      p         <= p_next;
      k         <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    sh         <= sh_next;
    bcd        <= bcd_next;
    flag_empty <= flag_empty_next;
    flag_oor   <= flag_oor_next;
    if (load) begin
      symbol       <= sym_d;
      last         <= last_d;
      empty_res    <= flag_empty;
      out_of_range <= flag_oor;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ST_IDLE)
    else $error("accepted word did not start conversion");

  a_flag_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (empty_res || out_of_range) |-> last && symbol == CH_NONE)
    else $error("flag word must be single and carry no character");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(empty_res && out_of_range))
    else $error("empty and out of range both set");

  a_split_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_SPLIT && $past(state) == ST_IDLE |-> cnt == '0)
    else $error("split counter not cleared on start");

endmodule
